// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_pkg: shared types and codes of the text console writer
// Holds the default geometry, the item kinds, control characters, cell constants,
// the configuration indexes and the result record.
// ============================================================================
package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Widths of the cursor fields on the result channel.
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;

  // Item kinds.
  localparam logic [1:0] KIND_PUT  = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Control characters.
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;
  // Cell layout: {back[3:0], fore[3:0], char[7:0]}.
  localparam logic [15:0] RESET_CELL = 16'h0720;

  // Configuration register indexes.
  localparam logic CFG_BACK_COLOR = 1'b0;
  localparam logic CFG_FORE_COLOR = 1'b1;

  // Result record; cursor_col sits in the lowest bits.
  typedef struct packed {
    logic                 scrolled;
    logic [3:0]           cell_back;
    logic [3:0]           cell_fore;
    logic [7:0]           cell_char;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
  } res_t;

endpackage

// File: rtl/core/tcw_screen_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_screen_mem: character cell store
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read request.
// ============================================================================
module tcw_screen_mem #(
  parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_ctrl: teletype sequencer
// Decodes one transaction at a time, keeps the cursor and the scroll origin,
// and drives the cell store: single writes, line blanking sweeps, reads and
// the clearing pass after reset.
// ============================================================================
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic [7:0]                         in_char,
  input  logic [7:0]                         in_col,
  input  logic [7:0]                         in_row,
  input  logic [3:0]                         back_color,
  input  logic [3:0]                         fore_color,
  output logic                               res_valid,
  input  logic                               res_ready,
  output tcw_pkg::res_t                      res,
  output logic                               mem_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]    mem_waddr,
  output logic [15:0]                        mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(COLUMNS*ROWS)-1:0]    mem_raddr,
  input  logic [15:0]                        mem_rdata
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(COLUMNS * ROWS);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  // Reciprocals scaled by 2^16 and rounded up.
  localparam logic [16:0] COL_RECIP = 17'((65536 + COLUMNS - 1) / COLUMNS);
  localparam logic [16:0] ROW_RECIP = 17'((65536 + ROWS - 1) / ROWS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_EXEC, S_WRITE, S_RDWAIT, S_BLANK, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [COL_W-1:0] sweep_col_r, sweep_col_nxt;
  logic [ROW_W-1:0] sweep_row_r, sweep_row_nxt;
  logic [ROW_W-1:0] blank_prow_r, blank_prow_nxt;
  logic [1:0]       op_kind_r, op_kind_nxt;
  logic [7:0]       op_char_r, op_char_nxt;
  logic [7:0]       op_col_raw_r, op_col_raw_nxt;
  logic [7:0]       op_row_raw_r, op_row_raw_nxt;
  logic [COL_W-1:0] op_col_r, op_col_nxt;
  logic [ROW_W-1:0] op_row_r, op_row_nxt;
  logic [7:0]       cell_char_r, cell_char_nxt;
  logic [3:0]       cell_fore_r, cell_fore_nxt;
  logic [3:0]       cell_back_r, cell_back_nxt;
  logic             scrolled_r, scrolled_nxt;

  logic [ROW_W-1:0]  a_prow;
  logic [COL_W-1:0]  a_col;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0]       blank_cell;
  logic [ROW_W-1:0]  top_inc;
  logic              is_read;

  // Logical row to stored row: the screen origin rotates on each scroll.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Remainder of a byte by a constant divisor through the scaled reciprocal.
  // The quotient estimate is exact for every byte as long as the divisor is
  // at most 256.
  function automatic logic [7:0] mod_byte(input logic [7:0]  value,
                                          input logic [16:0] recip,
                                          input logic [8:0]  divisor);
    logic [24:0] prod;
    logic [16:0] back;
    prod = {17'd0, value} * {8'd0, recip};
    back = {9'd0, prod[23:16]} * {8'd0, divisor};
    return value - back[7:0];
  endfunction

  assign blank_cell = {back_color & tcw_pkg::NIBBLE_MASK, fore_color & tcw_pkg::NIBBLE_MASK,
                       tcw_pkg::SPACE_CHAR};
  assign top_inc    = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
  assign is_read    = (op_kind_r == tcw_pkg::KIND_READ);

  always_comb begin
    case (state_r)
      S_CLEAR: begin
        a_prow = sweep_row_r;
        a_col  = sweep_col_r;
      end
      S_BLANK: begin
        a_prow = blank_prow_r;
        a_col  = sweep_col_r;
      end
      default: begin
        a_prow = phys_row(is_read ? op_row_r : cur_row_r, top_r);
        a_col  = is_read ? op_col_r : cur_col_r;
      end
    endcase
  end

  assign mem_addr  = ADDR_W'(a_prow) * ADDR_W'(COLUMNS) + ADDR_W'(a_col);
  assign mem_waddr = mem_addr;
  assign mem_raddr = mem_addr;

  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    top_nxt        = top_r;
    sweep_col_nxt  = sweep_col_r;
    sweep_row_nxt  = sweep_row_r;
    blank_prow_nxt = blank_prow_r;
    op_kind_nxt    = op_kind_r;
    op_char_nxt    = op_char_r;
    op_col_raw_nxt = op_col_raw_r;
    op_row_raw_nxt = op_row_raw_r;
    op_col_nxt     = op_col_r;
    op_row_nxt     = op_row_r;
    cell_char_nxt  = cell_char_r;
    cell_fore_nxt  = cell_fore_r;
    cell_back_nxt  = cell_back_r;
    scrolled_nxt   = scrolled_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wdata      = blank_cell;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::RESET_CELL;
        if (sweep_col_r == LAST_COL) begin
          sweep_col_nxt = '0;
          if (sweep_row_r == LAST_ROW) begin
            state_nxt = S_IDLE;
          end else begin
            sweep_row_nxt = sweep_row_r + 1'b1;
          end
        end else begin
          sweep_col_nxt = sweep_col_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_kind_nxt    = in_kind;
          op_char_nxt    = in_char;
          op_col_raw_nxt = in_col;
          op_row_raw_nxt = in_row;
          cell_char_nxt  = '0;
          cell_fore_nxt  = '0;
          cell_back_nxt  = '0;
          scrolled_nxt   = 1'b0;
          state_nxt      = S_DECODE;
        end
      end

      S_DECODE: begin
        op_col_nxt = COL_W'(mod_byte(op_col_raw_r, COL_RECIP, 9'(COLUMNS)));
        op_row_nxt = ROW_W'(mod_byte(op_row_raw_r, ROW_RECIP, 9'(ROWS)));
        state_nxt  = S_EXEC;
      end

      S_EXEC: begin
        case (op_kind_r)
          tcw_pkg::KIND_PUT: begin
            if (op_char_r == tcw_pkg::CH_LF || op_char_r == tcw_pkg::CH_CR) begin
              cur_col_nxt   = '0;
              sweep_col_nxt = '0;
              state_nxt     = S_BLANK;
              if (cur_row_r == LAST_ROW) begin
                // The old top line rotates around to become the new bottom line.
                top_nxt        = top_inc;
                blank_prow_nxt = top_r;
                scrolled_nxt   = 1'b1;
              end else begin
                cur_row_nxt    = cur_row_r + 1'b1;
                blank_prow_nxt = phys_row(cur_row_r + 1'b1, top_r);
              end
            end else if (op_char_r == tcw_pkg::CH_BS) begin
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - 1'b1;
              end else if (cur_row_r != '0) begin
                cur_col_nxt = LAST_COL;
                cur_row_nxt = cur_row_r - 1'b1;
              end
              state_nxt = S_WRITE;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {back_color & tcw_pkg::NIBBLE_MASK,
                           fore_color & tcw_pkg::NIBBLE_MASK, op_char_r};
              state_nxt = S_DONE;
              if (cur_col_r == LAST_COL) begin
                cur_col_nxt = '0;
                if (cur_row_r == LAST_ROW) begin
                  top_nxt        = top_inc;
                  blank_prow_nxt = top_r;
                  scrolled_nxt   = 1'b1;
                  sweep_col_nxt  = '0;
                  state_nxt      = S_BLANK;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
          end
          tcw_pkg::KIND_SET: begin
            cur_col_nxt = op_col_r;
            cur_row_nxt = op_row_r;
            state_nxt   = S_DONE;
          end
          tcw_pkg::KIND_READ: begin
            mem_re    = 1'b1;
            state_nxt = S_RDWAIT;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_RDWAIT: begin
        cell_char_nxt = mem_rdata[7:0];
        cell_fore_nxt = mem_rdata[11:8];
        cell_back_nxt = mem_rdata[15:12];
        state_nxt     = S_DONE;
      end

      S_BLANK: begin
        mem_we = 1'b1;
        if (sweep_col_r == LAST_COL) begin
          sweep_col_nxt = '0;
          state_nxt     = S_DONE;
        end else begin
          sweep_col_nxt = sweep_col_r + 1'b1;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      sweep_col_r <= '0;
      sweep_row_r <= '0;
      scrolled_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      top_r       <= top_nxt;
      sweep_col_r <= sweep_col_nxt;
      sweep_row_r <= sweep_row_nxt;
      scrolled_r  <= scrolled_nxt;
    end
    blank_prow_r <= blank_prow_nxt;
    op_kind_r    <= op_kind_nxt;
    op_char_r    <= op_char_nxt;
    op_col_raw_r <= op_col_raw_nxt;
    op_row_raw_r <= op_row_raw_nxt;
    op_col_r     <= op_col_nxt;
    op_row_r     <= op_row_nxt;
    cell_char_r  <= cell_char_nxt;
    cell_fore_r  <= cell_fore_nxt;
    cell_back_r  <= cell_back_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  assign res.scrolled   = scrolled_r;
  assign res.cell_back  = cell_back_r;
  assign res.cell_fore  = cell_fore_r;
  assign res.cell_char  = cell_char_r;
  assign res.cursor_row = tcw_pkg::OUT_ROW_W'(cur_row_r);
  assign res.cursor_col = tcw_pkg::OUT_COL_W'(cur_col_r);

endmodule

// File: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// ============================================================================
// text_console_writer: teletype engine over a character cell screen
// Puts characters at the cursor, handles newline, carriage return and
// backspace, moves the cursor, reads back cells and scrolls on overflow.
// ============================================================================
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  in_     | slave     | in_tvalid / in_tready  | tuser: kind; tdata: char, col, row
//  out_    | master    | out_tvalid / out_tready| tdata: cursor, cell, scrolled
//  cfg_    | write     | cfg_we                 | cfg_addr, cfg_wdata
//
// Every transaction is decoded, executed and answered before the next one is
// accepted; a read or a backspace adds a memory step (S_RDWAIT, S_WRITE), and
// a newline or a scroll blanks the line one cell a cycle.
// Scrolling rotates the screen origin, so no line is copied. After reset the
// store is cleared to 0x0720 with in_tready low.
// A result that waits on out_tready holds the next transaction before its result.
//
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], col_in[15:8], row_in[23:16]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
                                  // cell_fore[23:20], cell_back[27:24], scrolled[28]
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata
);

  localparam int ADDR_W = $clog2(COLUMNS * ROWS);

  logic [3:0]    back_color_r;
  logic [3:0]    fore_color_r;
  logic          out_valid_r;
  tcw_pkg::res_t out_res_r;

  logic              res_valid;
  logic              res_ready;
  tcw_pkg::res_t     res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_color_r <= 4'd0;
      fore_color_r <= 4'd7;
    end else if (cfg_we) begin
      case (cfg_addr)
        tcw_pkg::CFG_BACK_COLOR: back_color_r <= cfg_wdata;
        tcw_pkg::CFG_FORE_COLOR: fore_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_char    (in_tdata[7:0]),
    .in_col     (in_tdata[15:8]),
    .in_row     (in_tdata[23:16]),
    .back_color (back_color_r),
    .fore_color (fore_color_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcw_screen_mem #(
    .DEPTH  (COLUMNS * ROWS),
    .DATA_W (16)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: a finished result waits here for the downstream side.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  // One transaction in flight: acceptance closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction was in progress");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.cursor_col < COLUMNS) && (out_res_r.cursor_row < ROWS))
    else $error("cursor outside the screen");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.scrolled |->
      (out_res_r.cursor_col == '0) &&
      (out_res_r.cursor_row == tcw_pkg::OUT_ROW_W'(ROWS - 1)))
    else $error("scroll left the cursor away from the start of the last line");

endmodule

// File: dv/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_text_console_writer: self-checking bench for the text console writer
// Drives put, set-cursor, read and unused-kind transactions with random gaps
// and output stalls. A behavioral screen model predicts every result, and
// each result is checked field by field in arrival order. The color
// registers are changed between phases, only while the block is idle.
// ============================================================================
module tb_text_console_writer;

  localparam int COLS  = tcw_pkg::DEF_COLUMNS;
  localparam int NROWS = tcw_pkg::DEF_ROWS;
  localparam int CELLS = COLS * NROWS;
  // No transaction for this long means the block has hung.
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // char_code[7:0], col_in[15:8], row_in[23:16]
  logic [1:0]  in_tuser = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
                                // cell_fore[23:20], cell_back[27:24], scrolled[28]
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  // Screen model and the results it predicts, oldest first.
  logic [15:0]   screen_mem [0:CELLS-1];
  int unsigned   model_index;
  logic [3:0]    paint_back;
  logic [3:0]    paint_fore;
  tcw_pkg::res_t pending_results[$];

  bit            in_burst;
  bit            out_burst;
  int unsigned   error_count;
  int unsigned   items_sent;
  int unsigned   reads_sent;
  int unsigned   scrolls_seen;
  int unsigned   color_settings;
  int unsigned   idle_cycles;
  tcw_pkg::res_t got_res;
  tcw_pkg::res_t want_res;

  always #6 clk = ~clk;

  text_console_writer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic logic [15:0] blank_cell();
    return {paint_back, paint_fore, tcw_pkg::SPACE_CHAR};
  endfunction

  function automatic void blank_row(input int unsigned r);
    for (int i = 0; i < COLS; i++) begin
      screen_mem[r * COLS + i] = blank_cell();
    end
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++) begin
      screen_mem[i] = screen_mem[i + COLS];
    end
    blank_row(NROWS - 1);
    model_index = (NROWS - 1) * COLS;
  endfunction

  function automatic void reset_screen_model();
    for (int i = 0; i < CELLS; i++) begin
      screen_mem[i] = tcw_pkg::RESET_CELL;
    end
    model_index = 0;
    paint_back  = 4'd0;
    paint_fore  = 4'd7;
  endfunction

  function automatic tcw_pkg::res_t console_step(input logic [1:0] kind, input logic [7:0] ch,
                                                 input logic [7:0] col_raw,
                                                 input logic [7:0] row_raw);
    tcw_pkg::res_t r;
    int unsigned   col;
    int unsigned   row;
    int unsigned   next_row;
    logic [15:0]   stored;
    r = '0;
    col = col_raw % COLS;
    row = row_raw % NROWS;
    case (kind)
      tcw_pkg::KIND_PUT: begin
        if (ch == tcw_pkg::CH_LF || ch == tcw_pkg::CH_CR) begin
          next_row = model_index / COLS + 1;
          if (next_row >= NROWS) begin
            scroll_screen();
            r.scrolled = 1'b1;
          end else begin
            model_index = next_row * COLS;
            blank_row(next_row);
          end
        end else if (ch == tcw_pkg::CH_BS) begin
          if (model_index > 0) model_index--;
          screen_mem[model_index] = blank_cell();
        end else begin
          screen_mem[model_index] = {paint_back, paint_fore, ch};
          model_index++;
          if (model_index >= CELLS) begin
            scroll_screen();
            r.scrolled = 1'b1;
          end
        end
      end
      tcw_pkg::KIND_SET: begin
        model_index = row * COLS + col;
      end
      tcw_pkg::KIND_READ: begin
        stored = screen_mem[row * COLS + col];
        r.cell_char = stored[7:0];
        r.cell_fore = stored[11:8];
        r.cell_back = stored[15:12];
      end
      default: ;
    endcase
    r.cursor_col = tcw_pkg::OUT_COL_W'(model_index % COLS);
    r.cursor_row = tcw_pkg::OUT_ROW_W'(model_index / COLS);
    return r;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                           input logic [7:0] col, input logic [7:0] row);
    int unsigned   gap;
    tcw_pkg::res_t r;
    gap = in_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {row, col, ch};
    do @(posedge clk); while (!in_tready);
    r = console_step(kind, ch, col, row);
    pending_results.push_back(r);
    items_sent++;
    if (kind == tcw_pkg::KIND_READ) reads_sent++;
    if (r.scrolled) scrolls_seen++;
  endtask

  // Stops the input side and waits until the block has answered everything.
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (COLS + 8) @(posedge clk);
  endtask

  task automatic write_color(input logic addr, input logic [3:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == tcw_pkg::CFG_BACK_COLOR) paint_back = value;
    else paint_fore = value;
  endtask

  task automatic set_colors(input logic [3:0] back, input logic [3:0] fore);
    settle_block();
    write_color(tcw_pkg::CFG_BACK_COLOR, back);
    write_color(tcw_pkg::CFG_FORE_COLOR, fore);
    color_settings++;
  endtask

  // Result side: random stalls before each transaction, none in burst mode.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = tcw_pkg::res_t'(out_tdata[28:0]);
      if (pending_results.size() == 0) begin
        $error("result with no pending expectation: tdata %h", out_tdata);
        error_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.cursor_col !== want_res.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want_res.cursor_col, got_res.cursor_col);
          error_count++;
        end
        if (got_res.cursor_row !== want_res.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want_res.cursor_row, got_res.cursor_row);
          error_count++;
        end
        if (got_res.cell_char !== want_res.cell_char) begin
          $error("cell_char: expected %h, got %h", want_res.cell_char, got_res.cell_char);
          error_count++;
        end
        if (got_res.cell_fore !== want_res.cell_fore) begin
          $error("cell_fore: expected %h, got %h", want_res.cell_fore, got_res.cell_fore);
          error_count++;
        end
        if (got_res.cell_back !== want_res.cell_back) begin
          $error("cell_back: expected %h, got %h", want_res.cell_back, got_res.cell_back);
          error_count++;
        end
        if (got_res.scrolled !== want_res.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want_res.scrolled, got_res.scrolled);
          error_count++;
        end
        if (out_tdata[31:29] !== 3'b000) begin
          $error("tdata padding: expected 0, got %0d", out_tdata[31:29]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic apply_reset();
    reset_screen_model();
    rst_n <= 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Freshly cleared screen, including coordinates that wrap, and the unused kind.
  task automatic test_reset_contents();
    send_item(tcw_pkg::KIND_READ, 8'h00, 8'd0, 8'd0);
    send_item(tcw_pkg::KIND_READ, 8'h00, 8'(COLS - 1), 8'(NROWS - 1));
    send_item(tcw_pkg::KIND_READ, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_control_characters();
    set_colors(4'hF, 4'h0);
    send_item(tcw_pkg::KIND_PUT, 8'h00, 8'h00, 8'h00);
    send_item(tcw_pkg::KIND_PUT, 8'hFF, 8'hFF, 8'hFF);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BS, 8'h00, 8'h00);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BS, 8'h00, 8'h00);
    // Backspace at the origin still blanks the first cell.
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BS, 8'h00, 8'h00);
    send_item(tcw_pkg::KIND_READ, 8'h00, 8'd0, 8'd0);
    send_item(tcw_pkg::KIND_SET, 8'h00, 8'd10, 8'd3);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_CR, 8'h00, 8'h00);
    send_item(tcw_pkg::KIND_READ, 8'h00, 8'd5, 8'd4);
  endtask

  task automatic test_wrap_and_scroll();
    // Column 200 and row 99 land on column 40 of the last line.
    send_item(tcw_pkg::KIND_SET, 8'h00, 8'd200, 8'd99);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_LF, 8'h00, 8'h00);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_CR, 8'h00, 8'h00);
    send_item(tcw_pkg::KIND_READ, 8'h00, 8'd0, 8'(NROWS - 1));
    send_item(tcw_pkg::KIND_SET, 8'h00, 8'(COLS - 1), 8'(NROWS - 1));
    send_item(tcw_pkg::KIND_PUT, "A", 8'h00, 8'h00);
    send_item(tcw_pkg::KIND_READ, 8'h00, 8'(COLS - 1), 8'(NROWS - 2));
    send_item(tcw_pkg::KIND_READ, 8'h00, 8'd0, 8'd0);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0]  ch;
    logic [7:0]  c;
    logic [7:0]  r;
    pick = $urandom_range(0, 99);
    ch = 8'($urandom_range(32, 126));
    c = 8'($urandom_range(0, 255));
    r = 8'($urandom_range(0, 255));
    if (pick < 48) begin
      send_item(tcw_pkg::KIND_PUT, ch, c, r);
    end else if (pick < 53) begin
      send_item(tcw_pkg::KIND_PUT, 8'($urandom_range(0, 255)), c, r);
    end else if (pick < 60) begin
      send_item(tcw_pkg::KIND_PUT, $urandom_range(0, 1) ? tcw_pkg::CH_LF : tcw_pkg::CH_CR,
                c, r);
    end else if (pick < 66) begin
      send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BS, c, r);
    end else if (pick < 71) begin
      send_item(tcw_pkg::KIND_SET, 8'($urandom_range(0, 255)), c, r);
    end else if (pick < 78) begin
      // Near the end of the screen, so that scrolling happens often.
      send_item(tcw_pkg::KIND_SET, ch, 8'($urandom_range(COLS - 10, COLS - 1)),
                8'(NROWS - 1 - $urandom_range(0, 2)));
    end else if (pick < 88) begin
      send_item(tcw_pkg::KIND_READ, 8'($urandom_range(0, 255)), c, r);
    end else if (pick < 97) begin
      send_item(tcw_pkg::KIND_READ, ch, 8'($urandom_range(0, COLS - 1)),
                8'(model_index / COLS));
    end else begin
      send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), c, r);
    end
  endtask

  task automatic test_random_traffic(input int unsigned per_phase);
    logic [3:0] back_set [6];
    logic [3:0] fore_set [6];
    back_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0};
    fore_set = '{4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0};
    back_set[4] = 4'($urandom_range(0, 15));
    fore_set[4] = 4'($urandom_range(0, 15));
    back_set[5] = 4'($urandom_range(0, 15));
    fore_set[5] = 4'($urandom_range(0, 15));
    for (int p = 0; p < 6; p++) begin
      set_colors(back_set[p], fore_set[p]);
      in_burst  = (p == 2) || (p == 3);
      out_burst = (p == 2);
      for (int i = 0; i < per_phase; i++) begin
        send_random_item();
        // Hold the input side until the block has answered everything.
        if (i == per_phase / 2) settle_block();
      end
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  initial begin
    reset_screen_model();
    apply_reset();
    test_reset_contents();
    test_control_characters();
    test_wrap_and_scroll();
    test_random_traffic(305);
    settle_block();
    $display("Ran %0d transactions: %0d reads, %0d scrolls, %0d color settings.",
             items_sent, reads_sent, scrolls_seen, color_settings);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_screen_mem.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer.sv
dv/tb_text_console_writer.sv
